@@ rtl/core/hwpa_pkg.sv @@
// Package for the Huber weighted pixel accumulator.
// Holds widths, register indexes and shared stage types; no dependencies.
package hwpa_pkg;

  localparam int unsigned Pixels  = 4096;
  localparam int unsigned IdxW    = $clog2(Pixels);
  localparam int unsigned PixW    = 16;
  localparam int unsigned MeanW   = 24;
  localparam int unsigned SumW    = 64;
  localparam int unsigned TotW    = 48;
  localparam int unsigned EffW    = 25;
  // Residual quotient: |diff|*256 / std, capped at 32768.
  localparam int unsigned NumW    = 32;
  localparam int unsigned MagW    = 16;
  // Weight quotient: limit*65536 / mag, result below 2^16.
  localparam int unsigned WQW     = 17;

  localparam logic [15:0] HuberLimitRst = 16'd344;
  localparam logic [15:0] FrameGainRst  = 16'd256;

  typedef enum logic [0:0] {
    RegHuberLimit = 1'b0,
    RegFrameGain  = 1'b1
  } reg_idx_e;

  // Item state carried alongside the weight computation.
  typedef struct packed {
    logic [IdxW-1:0] idx;
    logic [PixW-1:0] pix;
  } item_t;

  // Result of the weight stages, handed to the accumulator.
  typedef struct packed {
    logic [IdxW-1:0] idx;
    logic [PixW-1:0] pix;
    logic [EffW-1:0] eff;
    logic            down;
  } wgt_t;

endpackage

@@ rtl/core/hwpa_weight.sv @@
// Weight pipeline: residual divide, Huber compare, weight divide, gain scale.
// Depends on hwpa_pkg. Two restoring dividers, one quotient bit per stage.
module hwpa_weight (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  hwpa_pkg::item_t          item_i,
  input  logic [hwpa_pkg::MeanW-1:0] mean_i,
  input  logic [hwpa_pkg::MeanW-1:0] std_i,
  input  logic [15:0]              limit_i,
  input  logic [15:0]              gain_i,
  output logic                     valid_o,
  output hwpa_pkg::wgt_t           wgt_o
);

  localparam int unsigned N1 = hwpa_pkg::NumW;   // quotient bits of divider one
  localparam int unsigned N2 = hwpa_pkg::WQW;    // quotient bits of divider two
  localparam int unsigned D1 = hwpa_pkg::MeanW + 1;
  localparam int unsigned D2 = hwpa_pkg::MagW + 1;

  // ---------------- stage A: difference ----------------
  logic                          a_v_q;
  hwpa_pkg::item_t               a_item_q;
  logic                          a_neg_q;
  logic [hwpa_pkg::MeanW-1:0]    a_abs_q;
  logic [hwpa_pkg::MeanW-1:0]    a_sd_q;
  logic [hwpa_pkg::MeanW-1:0]    scaled;
  logic                          neg_d;

  assign scaled = {item_i.pix, 8'd0};
  assign neg_d  = scaled < mean_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (en_i) begin
      a_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_item_q <= item_i;
      a_neg_q  <= neg_d;
      a_abs_q  <= neg_d ? mean_i - scaled : scaled - mean_i;
      a_sd_q   <= (std_i == '0) ? hwpa_pkg::MeanW'(1) : std_i;
    end
  end

  // ---------------- divider one: mag = (abs << 8) / sd ----------------
  logic                       d1_v_q   [N1+1];
  hwpa_pkg::item_t            d1_item_q[N1+1];
  logic                       d1_neg_q [N1+1];
  logic [N1-1:0]              d1_num_q [N1+1];
  logic [D1-1:0]              d1_rem_q [N1+1];
  logic [hwpa_pkg::MeanW-1:0] d1_den_q [N1+1];

  always_comb begin
    d1_v_q[0]    = a_v_q;
    d1_item_q[0] = a_item_q;
    d1_neg_q[0]  = a_neg_q;
    d1_num_q[0]  = {a_abs_q, 8'd0};
    d1_rem_q[0]  = '0;
    d1_den_q[0]  = a_sd_q;
  end

  for (genvar s = 0; s < N1; s++) begin : g_div1
    logic [D1-1:0] trial;
    logic          ge;
    assign trial = {d1_rem_q[s][D1-2:0], d1_num_q[s][N1-1]};
    assign ge    = trial >= {1'b0, d1_den_q[s]};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        d1_v_q[s+1] <= 1'b0;
      end else if (en_i) begin
        d1_v_q[s+1] <= d1_v_q[s];
      end
    end
    // Shift in one numerator bit, subtract when it fits, record quotient bit.
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        d1_item_q[s+1] <= d1_item_q[s];
        d1_neg_q[s+1]  <= d1_neg_q[s];
        d1_den_q[s+1]  <= d1_den_q[s];
        d1_rem_q[s+1]  <= ge ? trial - {1'b0, d1_den_q[s]} : trial;
        d1_num_q[s+1]  <= {d1_num_q[s][N1-2:0], ge};
      end
    end
  end

  // ---------------- stage B: saturate, compare ----------------
  logic                   b_v_q;
  hwpa_pkg::item_t        b_item_q;
  logic                   b_down_q;
  logic [hwpa_pkg::MagW-1:0] b_mag_q;
  logic [N1-1:0]          q1;
  logic [N1-1:0]          cap;
  logic [N1-1:0]          mag_c;

  assign q1    = d1_num_q[N1];
  assign cap   = d1_neg_q[N1] ? N1'(32768) : N1'(32767);
  assign mag_c = (q1 > cap) ? cap : q1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else if (en_i) begin
      b_v_q <= d1_v_q[N1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_item_q <= d1_item_q[N1];
      b_mag_q  <= mag_c[hwpa_pkg::MagW-1:0];
      b_down_q <= mag_c > N1'(limit_i);
    end
  end

  // ---------------- divider two: hw = (limit << 16) / mag ----------------
  logic                   d2_v_q   [N2+1];
  hwpa_pkg::item_t        d2_item_q[N2+1];
  logic                   d2_down_q[N2+1];
  logic [N2-1:0]          d2_num_q [N2+1];
  logic [D2-1:0]          d2_rem_q [N2+1];
  logic [hwpa_pkg::MagW-1:0] d2_den_q[N2+1];

  // Numerator limit*65536: quotient is below 2^16, so preload the upper
  // bits as the partial remainder (limit < mag) and develop 17 quotient bits.
  always_comb begin
    d2_v_q[0]    = b_v_q;
    d2_item_q[0] = b_item_q;
    d2_down_q[0] = b_down_q;
    d2_num_q[0]  = '0;
    d2_rem_q[0]  = {1'b0, limit_i};
    d2_den_q[0]  = b_mag_q;
  end

  for (genvar s = 0; s < N2; s++) begin : g_div2
    logic [D2:0] trial;
    logic        ge;
    assign trial = {d2_rem_q[s], 1'b0};
    assign ge    = trial >= {2'b0, d2_den_q[s]};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        d2_v_q[s+1] <= 1'b0;
      end else if (en_i) begin
        d2_v_q[s+1] <= d2_v_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        d2_item_q[s+1] <= d2_item_q[s];
        d2_down_q[s+1] <= d2_down_q[s];
        d2_den_q[s+1]  <= d2_den_q[s];
        d2_rem_q[s+1]  <= ge ? D2'(trial - {2'b0, d2_den_q[s]}) : D2'(trial);
        d2_num_q[s+1]  <= {d2_num_q[s][N2-2:0], ge};
      end
    end
  end

  // ---------------- stage C: select weight, scale by gain ----------------
  logic          c_v_q;
  hwpa_pkg::wgt_t c_q;
  logic [N2-1:0] hw;
  logic [N2+15:0] prod;

  // Limit*2^16/mag with mag > limit shifts one surplus bit; drop it.
  assign hw   = d2_down_q[N2] ? {1'b0, d2_num_q[N2][N2-1:1]} : N2'(65536);
  assign prod = hw * gain_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
    end else if (en_i) begin
      c_v_q <= d2_v_q[N2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q.idx  <= d2_item_q[N2].idx;
      c_q.pix  <= d2_item_q[N2].pix;
      c_q.down <= d2_down_q[N2];
      c_q.eff  <= prod[hwpa_pkg::EffW+7:8];
    end
  end

  assign valid_o = c_v_q;
  assign wgt_o   = c_q;

`ifndef ASSERT_OFF
  // Quotient of the weight divide never exceeds 1.0 on a downweighted item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    d2_v_q[N2] && d2_down_q[N2] |-> d2_num_q[N2][N2-1:1] <= 16'hFFFF)
    else $error("huber weight above one");
  // Residual magnitude stays within the saturation cap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_v_q |-> b_mag_q <= 16'd32768)
    else $error("residual magnitude beyond cap");
  // A frozen pipe keeps its output valid flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(c_v_q))
    else $error("weight pipe moved while frozen");
`endif

endmodule

@@ rtl/core/hwpa_accum.sv @@
// Accumulator: multiply pixel by weight, read-modify-write the per-pixel stores.
// Depends on hwpa_pkg. Memories with a clearing pass after reset.
module hwpa_accum (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  hwpa_pkg::wgt_t           wgt_i,
  output logic                     clearing_o,
  output logic                     valid_o,
  output logic [hwpa_pkg::SumW-1:0] sum_o,
  output logic [hwpa_pkg::TotW-1:0] tot_o,
  output logic                     down_o
);

  localparam int unsigned IW = hwpa_pkg::IdxW;
  localparam int unsigned SW = hwpa_pkg::SumW;
  localparam int unsigned TW = hwpa_pkg::TotW;
  localparam int unsigned PW = hwpa_pkg::PixW + hwpa_pkg::EffW;

  logic [SW-1:0] sum_mem [hwpa_pkg::Pixels];
  logic [TW-1:0] tot_mem [hwpa_pkg::Pixels];

  // Clear sweep over all entries after reset.
  logic          clr_q;
  logic [IW-1:0] clr_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_idx_q <= '0;
    end else if (clr_q) begin
      clr_idx_q <= clr_idx_q + 1'b1;
      if (clr_idx_q == IW'(hwpa_pkg::Pixels - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end
  assign clearing_o = clr_q;

  // Stage M: issue read, form product.
  logic           m_v_q;
  hwpa_pkg::wgt_t m_q;
  logic [PW-1:0]  m_prod_q;
  logic [SW-1:0]  m_rs_q;
  logic [TW-1:0]  m_rt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
    end else if (en_i) begin
      m_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q      <= wgt_i;
      m_prod_q <= wgt_i.pix * wgt_i.eff;
      m_rs_q   <= sum_mem[wgt_i.idx];
      m_rt_q   <= tot_mem[wgt_i.idx];
    end
  end

  // Stage U: add with saturation; forward the just-written entry.
  logic           u_v_q;
  logic [IW-1:0]  u_idx_q;
  logic [SW-1:0]  u_sum_q;
  logic [TW-1:0]  u_tot_q;
  logic           u_down_q;
  logic           fwd;
  logic [SW-1:0]  base_s;
  logic [TW-1:0]  base_t;
  logic [SW:0]    add_s;
  logic [TW:0]    add_t;

  assign fwd    = u_v_q && (u_idx_q == m_q.idx);
  assign base_s = fwd ? u_sum_q : m_rs_q;
  assign base_t = fwd ? u_tot_q : m_rt_q;
  assign add_s  = {1'b0, base_s} + (SW+1)'(m_prod_q);
  assign add_t  = {1'b0, base_t} + (TW+1)'(m_q.eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_v_q <= 1'b0;
    end else if (en_i) begin
      u_v_q <= m_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u_idx_q  <= m_q.idx;
      u_down_q <= m_q.down;
      u_sum_q  <= add_s[SW] ? '1 : add_s[SW-1:0];
      u_tot_q  <= add_t[TW] ? '1 : add_t[TW-1:0];
    end
  end

  // Write back: clear sweep or the stage M update.
  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      sum_mem[clr_idx_q] <= '0;
      tot_mem[clr_idx_q] <= '0;
    end else if (en_i && m_v_q) begin
      sum_mem[m_q.idx] <= add_s[SW] ? '1 : add_s[SW-1:0];
      tot_mem[m_q.idx] <= add_t[TW] ? '1 : add_t[TW-1:0];
    end
  end

  assign valid_o = u_v_q;
  assign sum_o   = u_sum_q;
  assign tot_o   = u_tot_q;
  assign down_o  = u_down_q;

`ifndef ASSERT_OFF
  // Nothing flows through the pipe while the stores are being cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !m_v_q && !u_v_q)
    else $error("item in pipe during clear");
  // A saturated total never falls back on the same pixel back to back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && fwd && m_v_q && u_tot_q == '1 |=> u_tot_q == '1)
    else $error("weight total left saturation");
`endif

endmodule

@@ rtl/core/huber_weighted_pixel_accumulate.sv @@
// Huber weighted pixel accumulator, top level.
// Takes one request per cycle while in_stall_o is low.
// The two bit-per-stage dividers are fully pipelined. Depends on hwpa_pkg.
// Reset: asynchronous active low; clears registers, then a pass over all
// 4096 entries zeroes the stores, during which in_stall_o is high.
module huber_weighted_pixel_accumulate (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [11:0] pixel_index_i,
  input  logic [15:0] pixel_value_i,
  input  logic [23:0] ref_mean_i,
  input  logic [23:0] ref_std_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] acc_sum_o,
  output logic [47:0] acc_weight_o,
  output logic        was_downweighted_o
);

  logic [15:0] limit_q;
  logic [15:0] gain_q;

  // Write configuration registers.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= hwpa_pkg::HuberLimitRst;
      gain_q  <= hwpa_pkg::FrameGainRst;
    end else if (cfg_valid_i) begin
      unique case (hwpa_pkg::reg_idx_e'(cfg_index_i))
        hwpa_pkg::RegHuberLimit: limit_q <= cfg_data_i;
        hwpa_pkg::RegFrameGain:  gain_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Whole pipe freezes while the output is stalled or the stores are cleared.
  logic            en;
  logic            clearing;
  logic            acc_v;
  logic            w_v;
  hwpa_pkg::wgt_t  w;
  hwpa_pkg::item_t item;

  assign en         = !(out_valid_o && out_stall_i) && !clearing;
  assign in_stall_o = !en;
  assign item.idx   = pixel_index_i;
  assign item.pix   = pixel_value_i;

  hwpa_weight u_weight (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .item_i  (item),
    .mean_i  (ref_mean_i),
    .std_i   (ref_std_i),
    .limit_i (limit_q),
    .gain_i  (gain_q),
    .valid_o (w_v),
    .wgt_o   (w)
  );

  hwpa_accum u_accum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (w_v),
    .wgt_i      (w),
    .clearing_o (clearing),
    .valid_o    (acc_v),
    .sum_o      (acc_sum_o),
    .tot_o      (acc_weight_o),
    .down_o     (was_downweighted_o)
  );

  assign out_valid_o = acc_v;

`ifndef ASSERT_OFF
  // No input request is taken during the clear pass.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> in_stall_o)
    else $error("input taken while clearing");
  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(acc_sum_o))
    else $error("stalled result changed");
  // Config port is always ready.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("config port not ready");
`endif

endmodule
